// ===== src/line_line_closest_intersect_unit_assert.svh =====
// assertion macros for the closest-intersection unit
`ifndef LINE_LINE_CLOSEST_INTERSECT_UNIT_ASSERT_SVH
`define LINE_LINE_CLOSEST_INTERSECT_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define LLCI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define LLCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/llci_pkg.sv =====
package llci_pkg;

  // coordinate format
  localparam int CoordBits = 32;
  localparam int FracBits  = 16;

  // derived widths
  localparam int K      = CoordBits + 1;        // origin difference, half of a wide operand
  localparam int OpW    = 2 * K;                // wide multiplier operand
  localparam int PW     = 4 * K;                // wide product and dot sum
  localparam int QuotW  = CoordBits + 2;        // quotient bits before saturation
  localparam int NumW   = PW + FracBits + 2;    // dividend
  localparam int CmpW   = PW + QuotW + 1;       // shifted divisor compare
  localparam int NumInFields = 12;
  localparam int InW    = NumInFields * CoordBits;
  localparam int OutW   = 2 * CoordBits;

  // register map
  localparam int  ThrBits   = 31;
  localparam logic [ThrBits-1:0] ThrReset = ThrBits'(2048);
  localparam logic RegThrIdx = 1'b0;

  typedef logic signed [CoordBits-1:0]   coord_t;
  typedef logic signed [K-1:0]           wv_t;
  typedef logic signed [2*CoordBits-1:0] dp_t;
  typedef logic signed [2*CoordBits:0]   ncw_t;
  typedef logic signed [OpW-1:0]         op_t;
  typedef logic signed [PW-1:0]          prod_t;

  typedef struct {
    coord_t o1[3];
    coord_t d1[3];
    coord_t o2[3];
    coord_t d2[3];
  } ray_pair_t;

  // values carried alongside the solve and the divider
  typedef struct {
    coord_t d1[3];
    coord_t d2[3];
    wv_t    w[3];
    logic   par;
    logic   neg1;
    logic   neg2;
  } side_t;

  typedef struct {
    logic [NumW-1:0] num1;
    logic [NumW-1:0] num2;
    logic [PW-1:0]   den;
    side_t           side;
  } div_in_t;

  typedef struct {
    logic [QuotW-1:0] q1;
    logic [QuotW-1:0] q2;
    logic             ov1;
    logic             ov2;
    side_t            side;
  } quot_t;

  typedef struct packed {
    logic           hit;
    logic           par;
    coord_t         t1;
    coord_t         t2;
  } result_t;

  // split product partials of a wide signed multiply
  typedef struct packed {
    logic signed [OpW-1:0] hh;
    logic signed [OpW:0]   hl;
    logic signed [OpW:0]   lh;
    logic [OpW-1:0]        ll;
  } pp_t;

  // next cyclic component index
  function automatic int nx(int k);
    return (k == 2) ? 0 : k + 1;
  endfunction

  // four narrow partial products of a*b
  function automatic pp_t pp_mul(op_t a, op_t b);
    pp_t r;
    logic signed [K-1:0] ah;
    logic signed [K-1:0] bh;
    logic signed [K:0]   al;
    logic signed [K:0]   bl;
    ah = a[OpW-1:K];
    bh = b[OpW-1:K];
    al = {1'b0, a[K-1:0]};
    bl = {1'b0, b[K-1:0]};
    r.hh = ah * bh;
    r.hl = ah * bl;
    r.lh = al * bh;
    r.ll = a[K-1:0] * b[K-1:0];
    return r;
  endfunction

  // recombine partial products
  function automatic prod_t pp_sum(pp_t p);
    prod_t hh;
    prod_t mid;
    prod_t ll;
    hh  = prod_t'(p.hh) <<< OpW;
    mid = (prod_t'(p.hl) + prod_t'(p.lh)) <<< K;
    ll  = prod_t'({1'b0, p.ll});
    return hh + mid + ll;
  endfunction

  // round-divided quotient to saturated signed parameter
  function automatic coord_t sat_param(logic [QuotW-1:0] q, logic ov, logic neg, logic par);
    logic [QuotW-1:0] lim;
    logic [QuotW-1:0] mag;
    lim = (QuotW'(1) << (CoordBits - 1)) - QuotW'(!neg);
    mag = (ov || (q > lim)) ? lim : q;
    if (neg) mag = -mag;
    return par ? '0 : coord_t'(mag[CoordBits-1:0]);
  endfunction

endpackage

// ===== src/llci_solve.sv =====
module llci_solve (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  llci_pkg::ray_pair_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output llci_pkg::div_in_t   out_data_o
);

  localparam int NS = 8;

  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  llci_pkg::side_t side_q [NS];
  llci_pkg::side_t s2_side;
  llci_pkg::side_t s6_side;

  llci_pkg::dp_t   s0_pa_q [3];
  llci_pkg::dp_t   s0_pb_q [3];
  llci_pkg::ncw_t  s1_n_q  [3];
  llci_pkg::ncw_t  s1_a1_q [3];
  llci_pkg::ncw_t  s1_b1_q [3];
  llci_pkg::ncw_t  s1_a2_q [3];
  llci_pkg::ncw_t  s1_b2_q [3];
  llci_pkg::ncw_t  s2_n_q  [3];
  llci_pkg::op_t   s2_c1_q [3];
  llci_pkg::op_t   s2_c2_q [3];
  llci_pkg::pp_t   s3_pn_q [3];
  llci_pkg::pp_t   s3_p1_q [3];
  llci_pkg::pp_t   s3_p2_q [3];
  llci_pkg::prod_t s4_xn_q [3];
  llci_pkg::prod_t s4_x1_q [3];
  llci_pkg::prod_t s4_x2_q [3];
  llci_pkg::prod_t s5_nn_q;
  llci_pkg::prod_t s5_e1_q;
  llci_pkg::prod_t s5_e2_q;
  logic [llci_pkg::PW-1:0] s6_nn_q;
  logic [llci_pkg::PW-1:0] s6_m1_q;
  logic [llci_pkg::PW-1:0] s6_m2_q;
  llci_pkg::div_in_t s7_q;

  // stage advance chain
  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = s7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // side values with the parallel flag and the numerator signs filled in
  always_comb begin
    s2_side     = side_q[1];
    s2_side.par = (s1_n_q[0] == '0) && (s1_n_q[1] == '0) && (s1_n_q[2] == '0);
    s6_side      = side_q[5];
    s6_side.neg1 = s5_e1_q[llci_pkg::PW-1];
    s6_side.neg2 = s5_e2_q[llci_pkg::PW-1];
  end

  // stage 0: origin difference, direction cross products
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int k = 0; k < 3; k++) begin
        side_q[0].d1[k] <= in_data_i.d1[k];
        side_q[0].d2[k] <= in_data_i.d2[k];
        side_q[0].w[k]  <= llci_pkg::wv_t'(in_data_i.o1[k]) -
                           llci_pkg::wv_t'(in_data_i.o2[k]);
        s0_pa_q[k] <= in_data_i.d1[llci_pkg::nx(k)] *
                      in_data_i.d2[llci_pkg::nx(llci_pkg::nx(k))];
        s0_pb_q[k] <= in_data_i.d1[llci_pkg::nx(llci_pkg::nx(k))] *
                      in_data_i.d2[llci_pkg::nx(k)];
      end
      side_q[0].par  <= 1'b0;
      side_q[0].neg1 <= 1'b0;
      side_q[0].neg2 <= 1'b0;
    end
  end

  // stage 1: normal, products of directions with origin difference
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      side_q[1] <= side_q[0];
      for (int k = 0; k < 3; k++) begin
        s1_n_q[k]  <= llci_pkg::ncw_t'(s0_pa_q[k]) - llci_pkg::ncw_t'(s0_pb_q[k]);
        s1_a1_q[k] <= side_q[0].d2[llci_pkg::nx(k)] *
                      side_q[0].w[llci_pkg::nx(llci_pkg::nx(k))];
        s1_b1_q[k] <= side_q[0].d2[llci_pkg::nx(llci_pkg::nx(k))] *
                      side_q[0].w[llci_pkg::nx(k)];
        s1_a2_q[k] <= side_q[0].d1[llci_pkg::nx(k)] *
                      side_q[0].w[llci_pkg::nx(llci_pkg::nx(k))];
        s1_b2_q[k] <= side_q[0].d1[llci_pkg::nx(llci_pkg::nx(k))] *
                      side_q[0].w[llci_pkg::nx(k)];
      end
    end
  end

  // stage 2: cross vectors, parallel flag
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      side_q[2] <= s2_side;
      for (int k = 0; k < 3; k++) begin
        s2_n_q[k]  <= s1_n_q[k];
        s2_c1_q[k] <= llci_pkg::op_t'(s1_a1_q[k]) - llci_pkg::op_t'(s1_b1_q[k]);
        s2_c2_q[k] <= llci_pkg::op_t'(s1_a2_q[k]) - llci_pkg::op_t'(s1_b2_q[k]);
      end
    end
  end

  // stage 3: partial products of the dot terms
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      side_q[3] <= side_q[2];
      for (int k = 0; k < 3; k++) begin
        s3_pn_q[k] <= llci_pkg::pp_mul(llci_pkg::op_t'(s2_n_q[k]),
                                       llci_pkg::op_t'(s2_n_q[k]));
        s3_p1_q[k] <= llci_pkg::pp_mul(s2_c1_q[k], llci_pkg::op_t'(s2_n_q[k]));
        s3_p2_q[k] <= llci_pkg::pp_mul(s2_c2_q[k], llci_pkg::op_t'(s2_n_q[k]));
      end
    end
  end

  // stage 4: recombine partials
  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      side_q[4] <= side_q[3];
      for (int k = 0; k < 3; k++) begin
        s4_xn_q[k] <= llci_pkg::pp_sum(s3_pn_q[k]);
        s4_x1_q[k] <= llci_pkg::pp_sum(s3_p1_q[k]);
        s4_x2_q[k] <= llci_pkg::pp_sum(s3_p2_q[k]);
      end
    end
  end

  // stage 5: dot sums
  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      side_q[5] <= side_q[4];
      s5_nn_q <= s4_xn_q[0] + s4_xn_q[1] + s4_xn_q[2];
      s5_e1_q <= s4_x1_q[0] + s4_x1_q[1] + s4_x1_q[2];
      s5_e2_q <= s4_x2_q[0] + s4_x2_q[1] + s4_x2_q[2];
    end
  end

  // stage 6: sign and magnitude of the numerators
  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      side_q[6] <= s6_side;
      s6_nn_q <= s5_nn_q;
      s6_m1_q <= s5_e1_q[llci_pkg::PW-1] ? -s5_e1_q : s5_e1_q;
      s6_m2_q <= s5_e2_q[llci_pkg::PW-1] ? -s5_e2_q : s5_e2_q;
    end
  end

  // stage 7: rounding dividend and divisor
  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      s7_q.side <= side_q[6];
      s7_q.num1 <= (llci_pkg::NumW'(s6_m1_q) << (llci_pkg::FracBits + 1)) +
                   llci_pkg::NumW'(s6_nn_q);
      s7_q.num2 <= (llci_pkg::NumW'(s6_m2_q) << (llci_pkg::FracBits + 1)) +
                   llci_pkg::NumW'(s6_nn_q);
      s7_q.den  <= s6_nn_q << 1;
    end
  end

endmodule

// ===== src/llci_divider.sv =====
module llci_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  llci_pkg::div_in_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output llci_pkg::quot_t   out_data_o
);

  localparam int NS = llci_pkg::QuotW + 1;

  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  logic [llci_pkg::NumW-1:0]  r1_q  [NS];
  logic [llci_pkg::NumW-1:0]  r2_q  [NS];
  logic [llci_pkg::QuotW-1:0] q1_q  [NS];
  logic [llci_pkg::QuotW-1:0] q2_q  [NS];
  logic [llci_pkg::PW-1:0]    den_q [NS];
  logic                       ov1_q [NS];
  logic                       ov2_q [NS];
  llci_pkg::side_t            side_q [NS];

  // stage advance chain
  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];

  always_comb begin
    out_data_o.q1   = q1_q[NS-1];
    out_data_o.q2   = q2_q[NS-1];
    out_data_o.ov1  = ov1_q[NS-1];
    out_data_o.ov2  = ov2_q[NS-1];
    out_data_o.side = side_q[NS-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: quotient too large for the bit count, then restoring steps,
  // one quotient bit per stage, msb first
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      r1_q[0]   <= in_data_i.num1;
      r2_q[0]   <= in_data_i.num2;
      q1_q[0]   <= '0;
      q2_q[0]   <= '0;
      den_q[0]  <= in_data_i.den;
      side_q[0] <= in_data_i.side;
      ov1_q[0]  <= llci_pkg::CmpW'(in_data_i.num1) >=
                   (llci_pkg::CmpW'(in_data_i.den) << llci_pkg::QuotW);
      ov2_q[0]  <= llci_pkg::CmpW'(in_data_i.num2) >=
                   (llci_pkg::CmpW'(in_data_i.den) << llci_pkg::QuotW);
    end
    for (int j = 1; j < NS; j++) begin
      if (adv[j]) begin
        logic [llci_pkg::CmpW-1:0] sh;
        sh = llci_pkg::CmpW'(den_q[j-1]) << (llci_pkg::QuotW - j);
        den_q[j]  <= den_q[j-1];
        side_q[j] <= side_q[j-1];
        ov1_q[j]  <= ov1_q[j-1];
        ov2_q[j]  <= ov2_q[j-1];
        if (llci_pkg::CmpW'(r1_q[j-1]) >= sh) begin
          r1_q[j] <= llci_pkg::NumW'(llci_pkg::CmpW'(r1_q[j-1]) - sh);
          q1_q[j] <= q1_q[j-1] | (llci_pkg::QuotW'(1) << (llci_pkg::QuotW - j));
        end else begin
          r1_q[j] <= r1_q[j-1];
          q1_q[j] <= q1_q[j-1];
        end
        if (llci_pkg::CmpW'(r2_q[j-1]) >= sh) begin
          r2_q[j] <= llci_pkg::NumW'(llci_pkg::CmpW'(r2_q[j-1]) - sh);
          q2_q[j] <= q2_q[j-1] | (llci_pkg::QuotW'(1) << (llci_pkg::QuotW - j));
        end else begin
          r2_q[j] <= r2_q[j-1];
          q2_q[j] <= q2_q[j-1];
        end
      end
    end
  end

endmodule

// ===== src/llci_gap.sv =====
module llci_gap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [2*llci_pkg::ThrBits-1:0] thr_sq_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  llci_pkg::quot_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output llci_pkg::result_t             out_data_o
);

  localparam int NS = 7;

  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  llci_pkg::side_t  side_q [NS-1];
  llci_pkg::coord_t t1_q   [NS-1];
  llci_pkg::coord_t t2_q   [NS-1];

  llci_pkg::dp_t   g1_p1_q [3];
  llci_pkg::dp_t   g1_p2_q [3];
  llci_pkg::op_t   g2_g_q  [3];
  llci_pkg::pp_t   g3_pp_q [3];
  llci_pkg::prod_t g4_sq_q [3];
  llci_pkg::prod_t g5_g2_q;
  llci_pkg::result_t res_q;

  // stage advance chain
  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: saturated parameters, then carried with the side values
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      side_q[0] <= in_data_i.side;
      t1_q[0] <= llci_pkg::sat_param(in_data_i.q1, in_data_i.ov1,
                                     in_data_i.side.neg1, in_data_i.side.par);
      t2_q[0] <= llci_pkg::sat_param(in_data_i.q2, in_data_i.ov2,
                                     in_data_i.side.neg2, in_data_i.side.par);
    end
    for (int j = 1; j < NS - 1; j++) begin
      if (adv[j]) begin
        side_q[j] <= side_q[j-1];
        t1_q[j]   <= t1_q[j-1];
        t2_q[j]   <= t2_q[j-1];
      end
    end
  end

  // stage 1: direction times parameter
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int k = 0; k < 3; k++) begin
        g1_p1_q[k] <= side_q[0].d1[k] * t1_q[0];
        g1_p2_q[k] <= side_q[0].d2[k] * t2_q[0];
      end
    end
  end

  // stage 2: gap vector between closest points
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int k = 0; k < 3; k++) begin
        g2_g_q[k] <= (llci_pkg::op_t'(side_q[1].w[k]) <<< llci_pkg::FracBits) +
                     llci_pkg::op_t'(g1_p1_q[k]) - llci_pkg::op_t'(g1_p2_q[k]);
      end
    end
  end

  // stage 3: partial products of the squares
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int k = 0; k < 3; k++) begin
        g3_pp_q[k] <= llci_pkg::pp_mul(g2_g_q[k], g2_g_q[k]);
      end
    end
  end

  // stage 4: recombine partials
  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      for (int k = 0; k < 3; k++) begin
        g4_sq_q[k] <= llci_pkg::pp_sum(g3_pp_q[k]);
      end
    end
  end

  // stage 5: squared gap
  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      g5_g2_q <= g4_sq_q[0] + g4_sq_q[1] + g4_sq_q[2];
    end
  end

  // stage 6: threshold compare, result word
  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      res_q.hit <= $unsigned(g5_g2_q) <=
                   (llci_pkg::PW'(thr_sq_i) << (2 * llci_pkg::FracBits));
      res_q.par <= side_q[5].par;
      res_q.t1  <= t1_q[5];
      res_q.t2  <= t2_q[5];
    end
  end

endmodule

// ===== src/line_line_closest_intersect_unit.sv =====
// Closest-approach test for two 3D rays in signed Q16.16. Each input word
// carries both origins and directions; the unit returns the two closest-point
// parameters (rounded to nearest, saturated), a parallel flag and a hit flag
// that is set when the closest points lie within distance_threshold. Parallel
// pairs report both parameters as zero and hit when the origins are within the
// threshold. The unit takes one ray pair every clock while the output is not
// held off; the result word passes through 50 register stages: 8 stages form
// the cross and dot products, 35 stages check for quotient overflow and then
// run the two restoring dividers one quotient bit per stage, and 7 stages
// saturate, rebuild the gap and compare. distance_threshold sits at byte
// address 0 of the register port and should only be changed while no words
// are in flight.
module line_line_closest_intersect_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // first_origin_x/y/z, first_dir_x/y/z, second_origin_x/y/z, second_dir_x/y/z
  input  logic [llci_pkg::InW-1:0]        s_axis_tdata,
  // master stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // first_param, second_param
  output logic [llci_pkg::OutW-1:0]       m_axis_tdata,
  // hit, parallel
  output logic [1:0]                     m_axis_tuser,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int C = llci_pkg::CoordBits;

  logic [llci_pkg::ThrBits-1:0]   thr_q;
  logic [2*llci_pkg::ThrBits-1:0] thr_sq_q;

  llci_pkg::ray_pair_t in_pair;
  llci_pkg::div_in_t   div_in;
  llci_pkg::quot_t     quot;
  llci_pkg::result_t   res;

  logic solve_valid;
  logic div_ready;
  logic div_valid;
  logic gap_ready;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == llci_pkg::RegThrIdx) ? {1'b0, thr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= llci_pkg::ThrReset;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == llci_pkg::RegThrIdx)) begin
      thr_q <= pwdata[llci_pkg::ThrBits-1:0];
    end
  end

  // squared threshold, follows the register
  always_ff @(posedge clk_i) begin
    thr_sq_q <= thr_q * thr_q;
  end

  // unpack the input word
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_pair.o1[k] = s_axis_tdata[k*C +: C];
      in_pair.d1[k] = s_axis_tdata[(3+k)*C +: C];
      in_pair.o2[k] = s_axis_tdata[(6+k)*C +: C];
      in_pair.d2[k] = s_axis_tdata[(9+k)*C +: C];
    end
  end

  llci_solve u_solve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (in_pair),
    .out_valid_o (solve_valid),
    .out_ready_i (div_ready),
    .out_data_o  (div_in)
  );

  llci_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (solve_valid),
    .in_ready_o  (div_ready),
    .in_data_i   (div_in),
    .out_valid_o (div_valid),
    .out_ready_i (gap_ready),
    .out_data_o  (quot)
  );

  llci_gap u_gap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_sq_i    (thr_sq_q),
    .in_valid_i  (div_valid),
    .in_ready_o  (gap_ready),
    .in_data_i   (quot),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  // pack the result word
  assign m_axis_tdata = {res.t2, res.t1};
  assign m_axis_tuser = {res.par, res.hit};

endmodule

// ===== src/llci_checker.sv =====
`include "line_line_closest_intersect_unit_assert.svh"

module llci_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [llci_pkg::InW-1:0]  s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [llci_pkg::OutW-1:0] m_axis_tdata,
  input logic [1:0]                m_axis_tuser,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic [2:0]                paddr,
  input logic [31:0]               pwdata,
  input logic [31:0]               prdata,
  input logic                      pready
);

  // a held word stays offered
  `LLCI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
    "result word dropped while stalled")

  // a held word keeps its payload
  `LLCI_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready,
    $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

  // an empty output never blocks the input
  `LLCI_ASSERT_NOW(a_in_open, !m_axis_tvalid, s_axis_tready,
    "input blocked with empty output")

  // threshold write reads back on the next cycle
  `LLCI_ASSERT_NEXT(a_thr_readback,
    psel && penable && pwrite && pready && (paddr[2] == llci_pkg::RegThrIdx),
    (paddr[2] != llci_pkg::RegThrIdx) ||
    (prdata == {1'b0, $past(pwdata[llci_pkg::ThrBits-1:0])}),
    "threshold readback mismatch")

endmodule

bind line_line_closest_intersect_unit llci_checker u_llci_checker (.*);
